FILE: src/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 digest unit: initial hash values,
// schedule word source codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int WORD_W     = 32;
    localparam int HASH_WORDS = 5;
    localparam int SCHED_LEN  = 16;
    localparam int ROUNDS     = 80;
    localparam int BYTES_W    = 61;
    localparam int FILL_W     = $clog2(SCHED_LEN);
    localparam int ROUND_W    = $clog2(ROUNDS);
    localparam int INDEX_W    = 3;
    localparam int DATA_W     = 40;   // 35 field bits padded to whole bytes

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // source of a word pushed into the schedule
    localparam logic [2:0] PS_INPUT  = 3'd0;
    localparam logic [2:0] PS_MARK   = 3'd1;
    localparam logic [2:0] PS_ZERO   = 3'd2;
    localparam logic [2:0] PS_LEN_HI = 3'd3;
    localparam logic [2:0] PS_LEN_LO = 3'd4;

    typedef struct packed {
        logic       accept;     // count bytes of the accepted request
        logic       push;       // shift a word into the schedule
        logic [2:0] push_sel;
        logic       round;      // run one compression round
        logic       final_add;  // fold working variables into the hash
        logic       out_next;   // step to the next digest word
        logic       hash_init;  // message done, back to initial state
    } sha1md_cmd_t;

    typedef struct packed {
        logic ends;        // accepted word closes the message
        logic full_word;   // four valid bytes
        logic fill_last;   // next push completes a block
        logic fill_14;     // two words left for the length
        logic round_last;  // round 79 in progress
        logic out_last;    // digest word 4 on the output
    } sha1md_status_t;

endpackage

FILE: src/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Controller: sequences input acceptance, padding pushes, the 80-round
// compression and delivery of the five digest words.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  sha1md_pkg::sha1md_status_t status,
    output sha1md_pkg::sha1md_cmd_t    cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MARK  = 3'd1;
    localparam logic [2:0] S_ZERO  = 3'd2;
    localparam logic [2:0] S_LENHI = 3'd3;
    localparam logic [2:0] S_LENLO = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] resume_reg, resume_next;
    logic [2:0] after;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            resume_reg <= S_IDLE;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        resume_next = resume_reg;
        after       = S_IDLE;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept   = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.push_sel = PS_INPUT;
                    if (status.ends)
                        after = status.full_word ? S_MARK : S_ZERO;
                    else
                        after = S_IDLE;
                end
            end
            S_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PS_MARK;
                after        = S_ZERO;
            end
            S_ZERO:
            begin
                if (status.fill_14)
                    state_next = S_LENHI;
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PS_ZERO;
                    after        = S_ZERO;
                end
            end
            S_LENHI:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PS_LEN_HI;
                after        = S_LENLO;
            end
            S_LENLO:
            begin
                cmd.push     = 1'b1;
                cmd.push_sel = PS_LEN_LO;
                after        = S_OUT;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.final_add = 1'b1;
                state_next    = resume_reg;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.out_last)
                    begin
                        cmd.hash_init = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                        cmd.out_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a push that completes a block runs the compression first
        if (cmd.push)
        begin
            if (status.fill_last)
            begin
                resume_next = after;
                state_next  = S_ROUND;
            end
            else
                state_next = after;
        end
    end

    // checks
    a_ready_vs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output handshakes active together");

    a_round_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && status.round_last) |=> state_reg == S_FINAL)
        else $error("compression did not end with the hash update");

    a_lenlo_compress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LENLO) |=> (state_reg == S_ROUND && resume_reg == S_OUT))
        else $error("length word did not complete a block");

endmodule

FILE: src/sha1md_dp.sv
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: 16-word schedule shift window, working variables, chaining hash,
// byte counter, block fill and round counters, digest output selection.
// ----------------------------------------------------------------------------
module sha1md_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sha1md_pkg::WORD_W-1:0] data_word,
    input  logic [2:0]                   valid_bytes,
    input  logic                         last,
    input  sha1md_pkg::sha1md_cmd_t      cmd,
    output sha1md_pkg::sha1md_status_t   status,
    output logic [sha1md_pkg::WORD_W-1:0] digest_word,
    output logic [sha1md_pkg::INDEX_W-1:0] word_index,
    output logic                         last_word
);
    import sha1md_pkg::*;

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;
    localparam logic [WORD_W-1:0] MARK_WORD = 32'h80000000;

    logic [WORD_W-1:0]  hash_reg [HASH_WORDS];
    logic [WORD_W-1:0]  wv_reg   [HASH_WORDS];
    logic [WORD_W-1:0]  win_reg  [SCHED_LEN];
    logic [FILL_W-1:0]  fill_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [INDEX_W-1:0] index_reg;

    logic [2:0]         n_bytes;
    logic [WORD_W-1:0]  short_word;
    logic [WORD_W-1:0]  push_word;
    logic [63:0]        bit_len;
    logic [WORD_W-1:0]  w_t;
    logic [WORD_W-1:0]  f_val;
    logic [WORD_W-1:0]  k_val;
    logic [WORD_W-1:0]  sum_val;
    logic [WORD_W-1:0]  x_val;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    // input word: clamp count, merge padding marker into a short word
    always_comb
    begin
        n_bytes = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (n_bytes)
            3'd0:    short_word = MARK_WORD;
            3'd1:    short_word = {data_word[31:24], 24'h800000};
            3'd2:    short_word = {data_word[31:16], 16'h8000};
            3'd3:    short_word = {data_word[31:8], 8'h80};
            default: short_word = data_word;
        endcase
    end

    assign bit_len = {bytes_reg, 3'b000};

    // word pushed into the schedule
    always_comb
    begin
        case (cmd.push_sel)
            PS_INPUT:  push_word = short_word;
            PS_MARK:   push_word = MARK_WORD;
            PS_LEN_HI: push_word = bit_len[63:32];
            PS_LEN_LO: push_word = bit_len[31:0];
            default:   push_word = '0;
        endcase
    end

    // round function
    always_comb
    begin
        x_val = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_t   = (round_reg < ROUND_W'(16)) ? win_reg[0] : rotl(x_val, 1);
        if (round_reg < ROUND_W'(20))
        begin
            f_val = (wv_reg[1] & wv_reg[2]) | (~wv_reg[1] & wv_reg[3]);
            k_val = K0;
        end
        else if (round_reg < ROUND_W'(40))
        begin
            f_val = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k_val = K1;
        end
        else if (round_reg < ROUND_W'(60))
        begin
            f_val = (wv_reg[1] & wv_reg[2]) | (wv_reg[1] & wv_reg[3])
                  | (wv_reg[2] & wv_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k_val = K3;
        end
        sum_val = rotl(wv_reg[0], 5) + f_val + wv_reg[4] + w_t + k_val;
    end

    // schedule window and working variables, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            for (int i = 0; i < SCHED_LEN - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[SCHED_LEN-1] <= push_word;
            // block complete: load working variables from the hash
            if (fill_reg == FILL_W'(SCHED_LEN - 1))
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    wv_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < SCHED_LEN - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[SCHED_LEN-1] <= w_t;
            wv_reg[4] <= wv_reg[3];
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= rotl(wv_reg[1], 30);
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= sum_val;
        end
    end

    // hash, counters and output index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                hash_reg[i] <= INIT_HASH[i];
            fill_reg  <= '0;
            bytes_reg <= '0;
            round_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
                bytes_reg <= bytes_reg + BYTES_W'(n_bytes);
            if (cmd.push)
                fill_reg <= fill_reg + FILL_W'(1);
            if (cmd.round)
            begin
                if (round_reg == ROUND_W'(ROUNDS - 1))
                    round_reg <= '0;
                else
                    round_reg <= round_reg + ROUND_W'(1);
            end
            if (cmd.final_add)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
            end
            if (cmd.out_next)
                index_reg <= index_reg + INDEX_W'(1);
            if (cmd.hash_init)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    hash_reg[i] <= INIT_HASH[i];
                bytes_reg <= '0;
                index_reg <= '0;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        status.ends       = last || (n_bytes != 3'd4);
        status.full_word  = (n_bytes == 3'd4);
        status.fill_last  = (fill_reg == FILL_W'(SCHED_LEN - 1));
        status.fill_14    = (fill_reg == FILL_W'(SCHED_LEN - 2));
        status.round_last = (round_reg == ROUND_W'(ROUNDS - 1));
        status.out_last   = (index_reg == INDEX_W'(HASH_WORDS - 1));
    end

    // digest output
    always_comb
    begin
        case (index_reg)
            3'd0:    digest_word = hash_reg[0];
            3'd1:    digest_word = hash_reg[1];
            3'd2:    digest_word = hash_reg[2];
            3'd3:    digest_word = hash_reg[3];
            default: digest_word = hash_reg[4];
        endcase
        word_index = index_reg;
        last_word  = status.out_last;
    end

endmodule

FILE: src/sha1_message_digest_unit.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// SHA-1 digest of a byte stream in big-endian words: padding, length and
// 80-round compression, then five digest words on the output stream.
// ----------------------------------------------------------------------------
// A word that does not end the message goes straight into the schedule; the sixteenth word
// of a block also starts the 80-round compression on one round unit and the hash update.
// An ending word then takes up to 16 padding pushes and one or two block
// compressions before the five digest words, one per output request.
// One message at a time; no new word is taken during compression or digest output.
// Reset loads the initial hash and clears the counters; the schedule window
// and working variables are not reset and are always written before use.
module sha1_message_digest_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sha1md_pkg::DATA_W-1:0] s_tdata,   // data_word[31:0], valid_bytes[34:32], zero
    input  logic                          s_tlast,   // last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sha1md_pkg::DATA_W-1:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic                          m_tlast    // last_word
);
    import sha1md_pkg::*;

    sha1md_cmd_t        cmd;
    sha1md_status_t     status;
    logic [WORD_W-1:0]  digest_word;
    logic [INDEX_W-1:0] word_index;

    sha1md_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sha1md_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_word   (s_tdata[31:0]),
        .valid_bytes (s_tdata[34:32]),
        .last        (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_tlast)
    );

    assign m_tdata = {5'b00000, word_index, digest_word};

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sha1_message_digest_unit. Byte messages go in as
// big-endian words on the slave stream. A built-in SHA-1 model predicts the
// five digest words of every message, and these are checked in order against
// the master stream. A short directed table comes first, then random messages
// of varied length, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sha1md_pkg::*;

    localparam int RANDOM_ITEMS = 440;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 40;    // digest words seen before the long stall

    // one row of the directed table; a typed digest overrides the prediction
    typedef struct packed {
        logic [31:0]  word;
        logic [2:0]   nbytes;
        logic         last;
        logic [7:0]   reps;
        logic         has_digest;
        logic [159:0] digest;
    } msg_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam int N_ROWS = 11;
    localparam msg_row_t DIRECTED [N_ROWS] = '{
        // empty word ends an empty message
        '{32'h00000000, 3'd0, 1'b0, 8'd1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        // "abc" in a short word
        '{32'h61626300, 3'd3, 1'b0, 8'd1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        // "abc" again, junk in the unused byte, last flag set
        '{32'h616263ff, 3'd3, 1'b1, 8'd1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{32'hffffffff, 3'd4, 1'b1, 8'd1, 1'b0, 160'h0},
        // oversized counts, mid-message and ending
        '{32'hffffffff, 3'd7, 1'b0, 8'd1, 1'b0, 160'h0},
        '{32'h00000000, 3'd5, 1'b0, 8'd1, 1'b0, 160'h0},
        '{32'h12345678, 3'd6, 1'b1, 8'd1, 1'b0, 160'h0},
        '{32'hdeadbeef, 3'd1, 1'b0, 8'd1, 1'b0, 160'h0},
        '{32'ha5a5a5a5, 3'd2, 1'b1, 8'd1, 1'b0, 160'h0},
        // fourteen full words: padding spills into a second block
        '{32'h0f0f0f0f, 3'd4, 1'b0, 8'd13, 1'b0, 160'h0},
        '{32'hf0f0f0f0, 3'd4, 1'b1, 8'd1, 1'b0, 160'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // predictor state
    logic [31:0] run_hash [HASH_WORDS];
    logic [31:0] blk_words [SCHED_LEN];
    int unsigned blk_fill;
    logic [60:0] byte_total;

    digest_beat_t digest_due [$];
    int unsigned  mismatches  = 0;
    int unsigned  beats_seen  = 0;
    int unsigned  items_sent;
    int unsigned  cycle_count = 0;
    bit           no_idle;

    sha1_message_digest_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // 80 rounds over the circular 16-word window, then fold into the chain
    function automatic void compress_schedule();
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int          s;
        a = run_hash[0];
        b = run_hash[1];
        c = run_hash[2];
        d = run_hash[3];
        e = run_hash[4];
        for (int r = 0; r < 80; r++)
        begin
            s = r & 15;
            if (r >= 16)
            begin
                x = blk_words[(s + 13) & 15] ^ blk_words[(s + 8) & 15] ^
                    blk_words[(s + 2) & 15] ^ blk_words[s];
                blk_words[s] = {x[30:0], x[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = {a[26:0], a[31:27]} + f + e + blk_words[s] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        run_hash[0] += a;
        run_hash[1] += b;
        run_hash[2] += c;
        run_hash[3] += d;
        run_hash[4] += e;
    endfunction

    function automatic void schedule_push(input logic [31:0] w);
        blk_words[blk_fill] = w;
        blk_fill++;
        if (blk_fill == SCHED_LEN)
        begin
            compress_schedule();
            blk_fill = 0;
        end
    endfunction

    // absorb one request; returns 1 with the digest when the message closes
    function automatic bit absorb_request(input logic [31:0] w, input logic [2:0] n,
                                          input logic l, output logic [159:0] digest);
        int unsigned nb;
        bit          closes;
        logic [31:0] keep;
        logic [63:0] bit_len;
        nb     = (n > 4) ? 4 : n;
        closes = l || (nb < 4);
        digest = '0;
        byte_total += 61'(nb);
        if (!closes)
        begin
            schedule_push(w);
            return 0;
        end
        if (nb == 4)
        begin
            schedule_push(w);
            schedule_push(32'h80000000);
        end
        else
        begin
            keep = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nb));
            schedule_push((w & keep) | (32'h80 << (24 - 8 * nb)));
        end
        // no room for the length: zero-fill and compress first
        if (blk_fill > 14)
        begin
            while (blk_fill != 0)
                schedule_push(32'h0);
        end
        while (blk_fill < 14)
            schedule_push(32'h0);
        bit_len = {byte_total, 3'b000};
        schedule_push(bit_len[63:32]);
        schedule_push(bit_len[31:0]);
        digest = {run_hash[0], run_hash[1], run_hash[2], run_hash[3], run_hash[4]};
        for (int i = 0; i < HASH_WORDS; i++)
            run_hash[i] = INIT_HASH[i];
        byte_total = '0;
        blk_fill   = 0;
        return 1;
    endfunction

    // offer one request from a falling edge, hold until taken, then predict
    task automatic send_request(input logic [31:0] w, input logic [2:0] n, input logic l,
                                input bit typed, input logic [159:0] typed_digest);
        logic [159:0] digest;
        digest_beat_t beat;
        while (!no_idle && $urandom_range(99, 0) < 7)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, n, w};
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (absorb_request(w, n, l, digest))
        begin
            if (typed)
                digest = typed_digest;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                beat.word  = digest[159 - 32 * i -: 32];
                beat.index = 3'(i);
                beat.last  = (i == HASH_WORDS - 1);
                digest_due.push_back(beat);
            end
        end
        @(negedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        int          body_len;
        logic [2:0]  n;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        rst_n      = 1'b0;
        no_idle    = 1'b0;
        items_sent = 0;
        byte_total = '0;
        blk_fill   = 0;
        for (int i = 0; i < HASH_WORDS; i++)
            run_hash[i] = INIT_HASH[i];
        for (int i = 0; i < SCHED_LEN; i++)
            blk_words[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++)
            for (int k = 0; k < DIRECTED[r].reps; k++)
                send_request(DIRECTED[r].word, DIRECTED[r].nbytes, DIRECTED[r].last,
                             DIRECTED[r].has_digest, DIRECTED[r].digest);

        // random messages, mostly well formed, some stray requests
        while (items_sent < N_ROWS + 12 + RANDOM_ITEMS)
        begin
            no_idle = (items_sent >= 200) && (items_sent < 320);
            if ($urandom_range(99, 0) < 85)
            begin
                body_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17)
                                                       : $urandom_range(17, 0);
                for (int k = 0; k < body_len; k++)
                begin
                    n = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
                    send_request($urandom(), n, 1'b0, 1'b0, '0);
                end
                n = 3'($urandom_range(7, 0));
                send_request($urandom(), n, (n < 4) ? 1'($urandom_range(1, 0)) : 1'b1,
                             1'b0, '0);
            end
            else
            begin
                send_request($urandom(), 3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                             1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow for any late stray output
        while (digest_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("sha1_message_digest_unit verification clean");
        else
            $display("sha1_message_digest_unit verification failed");
        $finish;
    end

    // output side: random back-pressure plus one long stall
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && beats_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= no_idle || ($urandom_range(99, 0) >= 7);
        end
    end

    // digest word checker
    always @(posedge clk)
    begin
        digest_beat_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.word  = m_tdata[31:0];
            got.index = m_tdata[34:32];
            got.last  = m_tlast;
            beats_seen++;
            if (digest_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h index %0d last %b",
                             got.word, got.index, got.last);
            end
            else
            begin
                want = digest_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"digest mismatch: expected %h idx %0d last %b, ",
                                  "got %h idx %0d last %b"},
                                 want.word, want.index, want.last,
                                 got.word, got.index, got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sha1_message_digest_unit verification failed");
            $finish;
        end
    end

endmodule
